@@ design/sva_pkg.sv @@
// ----------------------------------------------------------------------------
// sva_pkg: shared types and constants of the voice allocator
// Voice count, request and result payloads, the search token handed along
// the cell chain and the write bundle broadcast to the cells.
// ----------------------------------------------------------------------------
package sva_pkg;

  localparam int VOICE_COUNT = 8;
  localparam int IDX_W       = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int ENT_W       = 16;
  localparam int CH_W        = 4;
  localparam int LEN_W       = 24;
  localparam int NOW_W       = 31;
  localparam int END_W       = 32;
  localparam int LEFT_W      = END_W + 2;

  // Time left must be below this for a voice to be stolen
  localparam logic signed [LEFT_W-1:0] BEST_INIT = 34'sh0_7fff_ffff;

  // Sub-channel codes
  localparam logic [CH_W-1:0] CH_NONE = 4'b0000;
  localparam logic [CH_W-1:0] CH_ANY  = 4'b1111;

  // Request codes; the fourth code does nothing
  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_STOP  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef struct packed {
    logic [1:0]             action;
    logic [ENT_W-1:0]       entity;
    logic signed [CH_W-1:0] entity_channel;
    logic [LEN_W-1:0]       sound_length;
    logic [NOW_W-1:0]       now;
    logic                   audible;
  } req_t;

  typedef struct packed {
    logic       granted;
    logic [2:0] voice_index;
    logic       playing;
    logic       was_active;
  } res_t;

  // Search token walking the chain
  typedef struct packed {
    logic              valid;
    logic              done;
    logic              found;
    logic [IDX_W-1:0]  idx;
    logic [LEFT_W-1:0] best;
    logic              was;
  } cand_t;

  // Table update broadcast to all cells
  typedef struct packed {
    logic             we;
    logic             clr;
    logic             stop;
    logic [IDX_W-1:0] idx;
    logic [ENT_W-1:0] owner;
    logic [CH_W-1:0]  sub;
    logic [END_W-1:0] end_time;
    logic             active;
  } cell_wr_t;

endpackage

@@ design/sva_if.sv @@
// ----------------------------------------------------------------------------
// sva_if: request and result channels of the voice allocator
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface sva_req_if;
  import sva_pkg::*;
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sva_res_if;
  import sva_pkg::*;
  logic valid;
  logic ready;
  res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ design/sound_voice_allocator.sv @@
// ----------------------------------------------------------------------------
// sound_voice_allocator: voice table with voice stealing
// Start, stop and clear requests on a table of playback voices, searched by
// a token walking a chain of voice cells.
// ----------------------------------------------------------------------------
//   channel   dir   payload                                         handshake
//   req       in    action, entity, entity_channel, sound_length,   valid/ready
//                   now, audible
//   res       out   granted, voice_index, playing, was_active       valid/ready
//   cfg       in    view_entity (cfg_wr_data)                       cfg_wr_en
//
// For each request the search token moves one cell per cycle along the voice
// chain after a launch register feeds it in; the scan state then latches it,
// the done state writes the table and the result register, and the block
// returns to idle for the next request transfer.
// Reset clears the table and the listener entity.
// A new request is taken while the previous result still waits; if the
// result register is still full at write time, the block holds there.
// ----------------------------------------------------------------------------
module sound_voice_allocator import sva_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  sva_req_if.sink          req,
  sva_res_if.source        res,
  input  logic             cfg_wr_en,
  input  logic [ENT_W-1:0] cfg_wr_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t           state;
  logic [ENT_W-1:0] view_entity;
  req_t             cur;
  logic             launch;
  cand_t            fin;
  logic             res_valid;
  res_t             res_data;

  cand_t            chain [VOICE_COUNT+1];
  logic [VOICE_COUNT-1:0] tok_v;
  cell_wr_t         wr;
  logic             res_free;
  logic [IDX_W+2:0] idx_ext;
  logic             start_hit;
  logic             stop_hit;

  assign req.ready     = (state == S_IDLE);
  assign res.valid     = res_valid;
  assign res.payload   = res_data;
  assign res_free      = !res_valid || res.ready;

  // Feed a fresh token into the first cell
  always_comb begin
    chain[0]       = '0;
    chain[0].valid = launch;
    chain[0].best  = BEST_INIT;
  end

  // Voice cells
  for (genvar g = 0; g < VOICE_COUNT; g++) begin : g_cell
    sva_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cell_idx    (IDX_W'(g)),
      .req         (cur),
      .view_entity (view_entity),
      .wr          (wr),
      .cand_in     (chain[g]),
      .cand_out    (chain[g+1])
    );
    assign tok_v[g] = chain[g+1].valid;
  end

  // Build the table update from the finished search
  always_comb begin
    start_hit   = (cur.action == ACT_START) && fin.found;
    stop_hit    = (cur.action == ACT_STOP) && fin.found;
    wr          = '0;
    wr.idx      = fin.idx;
    wr.owner    = cur.entity;
    wr.sub      = cur.entity_channel;
    wr.stop     = stop_hit;
    wr.active   = start_hit && cur.audible;
    wr.end_time = (start_hit && cur.audible) ?
                  ({1'b0, cur.now} + {8'b0, cur.sound_length}) : '0;
    if ((state == S_DONE) && res_free) begin
      wr.we  = start_hit || stop_hit;
      wr.clr = (cur.action == ACT_CLEAR);
    end
    idx_ext = {3'b000, fin.idx};
  end

  // Sequence one request and hold the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      view_entity <= '0;
      launch      <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      launch <= (state == S_IDLE) && req.valid;
      if (cfg_wr_en) begin
        view_entity <= cfg_wr_data;
      end
      // Drop a delivered result unless a new one is loaded now
      if (res_valid && res.ready && (state != S_DONE)) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cur    <= req.payload;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (chain[VOICE_COUNT].valid) begin
            fin   <= chain[VOICE_COUNT];
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_free) begin
            res_valid            <= 1'b1;
            res_data.granted     <= start_hit || stop_hit;
            res_data.voice_index <= (start_hit || stop_hit) ? idx_ext[2:0] : 3'b000;
            res_data.playing     <= start_hit && cur.audible;
            res_data.was_active  <= (start_hit || stop_hit) && fin.was;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // Only one search token is ever in the chain
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(tok_v) <= 1)
    else $error("more than one token in the voice chain");

  // A request is taken only with the chain empty
  a_take_empty: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |-> (tok_v == '0) && !launch)
    else $error("request taken while a search is running");

  // The token leaves the chain only while a search is running
  a_exit_scan: assert property (@(posedge clk) disable iff (rst)
    chain[VOICE_COUNT].valid |-> (state == S_SCAN))
    else $error("token left the chain outside a search");

  // Every table update comes with a result
  a_wr_result: assert property (@(posedge clk) disable iff (rst)
    (wr.we || wr.clr) |=> res_valid)
    else $error("table written without a result");
`endif

endmodule

@@ design/sva_cell.sv @@
// ----------------------------------------------------------------------------
// sva_cell: one voice of the allocator table
// Holds one voice and updates the search token passing through it by one
// step of the start or stop scan, handing it on to the next cell.
// ----------------------------------------------------------------------------
module sva_cell import sva_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] cell_idx,
  input  req_t             req,
  input  logic [ENT_W-1:0] view_entity,
  input  cell_wr_t         wr,
  input  cand_t            cand_in,
  output cand_t            cand_out
);

  logic [ENT_W-1:0] owner;
  logic [CH_W-1:0]  sub;
  logic [END_W-1:0] end_time;
  logic             active;

  logic                     own_match;
  logic                     stop_match;
  logic                     protect;
  logic signed [LEFT_W-1:0] left;
  logic signed [LEFT_W-1:0] best_in;
  cand_t                    cand_next;

  // Compare this voice against the request
  always_comb begin
    own_match  = (req.entity_channel != CH_NONE) && (owner == req.entity) &&
                 ((sub == req.entity_channel) || (req.entity_channel == CH_ANY));
    stop_match = (owner == req.entity) && (sub == req.entity_channel);
    protect    = (owner == view_entity) && (req.entity != view_entity) && active;
    left       = $signed({2'b00, end_time}) - $signed({3'b000, req.now});
    best_in    = cand_in.best;
  end

  // Advance the token by one voice
  always_comb begin
    cand_next = cand_in;
    if (!cand_in.done) begin
      case (req.action)
        ACT_START: begin
          if (own_match) begin
            cand_next.found = 1'b1;
            cand_next.done  = 1'b1;
            cand_next.idx   = cell_idx;
            cand_next.was   = active;
          end else if (!protect && (left < best_in)) begin
            cand_next.found = 1'b1;
            cand_next.idx   = cell_idx;
            cand_next.best  = left;
            cand_next.was   = active;
          end
        end
        ACT_STOP: begin
          if (stop_match) begin
            cand_next.found = 1'b1;
            cand_next.done  = 1'b1;
            cand_next.idx   = cell_idx;
            cand_next.was   = active;
          end
        end
        default: begin
          cand_next = cand_in;
        end
      endcase
    end
  end

  // Hold the voice and the outgoing token
  always_ff @(posedge clk) begin
    if (rst) begin
      cand_out <= '0;
    end else begin
      cand_out <= cand_next;
    end
    if (rst || wr.clr) begin
      owner    <= '0;
      sub      <= '0;
      end_time <= '0;
      active   <= 1'b0;
    end else if (wr.we && (wr.idx == cell_idx)) begin
      if (!wr.stop) begin
        owner <= wr.owner;
        sub   <= wr.sub;
      end
      end_time <= wr.end_time;
      active   <= wr.active;
    end
  end

endmodule
